FILE: hdl/tapehw_pkg.sv
// ----------------------------------------------------------------------------
// tapehw_pkg: shared types and constants of the half-wave encoder
// Action codes, register indexes, field widths and the command that the
// front part hands through the queue to the back part.
// ----------------------------------------------------------------------------
package tapehw_pkg;

  localparam int ACTION_W   = 2;
  localparam int VALUE_W    = 16;
  localparam int SYNC_W     = 5;
  localparam int LEVEL_W    = 16;
  localparam int LEN_W      = 8;
  localparam int AMP_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Longest burst is a sync run: 31 short half-waves plus the long one.
  localparam int PAT_W      = 32;
  localparam int COUNT_W    = 6;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;

  localparam logic [ACTION_W-1:0] ACT_SYNC  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WORD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CHECK = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP   = 2'd2;

  localparam logic [LEN_W-1:0] SHORT_RESET = 8'd13;
  localparam logic [LEN_W-1:0] LONG_RESET  = 8'd26;
  localparam logic [AMP_W-1:0] AMP_RESET   = 15'd10000;

  // Bits to send, MSB first, and how many of them.
  typedef struct packed {
    logic [PAT_W-1:0]   bits;
    logic [COUNT_W-1:0] count;
  } tapehw_cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0] short_len;
    logic [LEN_W-1:0] long_len;
    logic [AMP_W-1:0] amp;
  } tapehw_cfg_t;

  // Queue state seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } tapehw_qstat_t;

endpackage

FILE: hdl/tapehw_if.sv
// ----------------------------------------------------------------------------
// tapehw_if: channel interfaces of the half-wave encoder
// Input item channel, half-wave result channel and register write channel.
// ----------------------------------------------------------------------------
interface tapehw_in_if;
  logic                            valid;
  logic                            ready;
  logic [tapehw_pkg::ACTION_W-1:0] action;
  logic [tapehw_pkg::VALUE_W-1:0]  value;
  logic [tapehw_pkg::SYNC_W-1:0]   sync_count;

  modport source (output valid, action, value, sync_count, input ready);
  modport sink   (input valid, action, value, sync_count, output ready);
endinterface

interface tapehw_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tapehw_pkg::LEVEL_W-1:0] level;
  logic [tapehw_pkg::LEN_W-1:0]          duration;
  logic                                  last;

  modport source (output valid, level, duration, last, input ready);
  modport sink   (input valid, level, duration, last, output ready);
endinterface

interface tapehw_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tapehw_pkg::CFG_IDX_W-1:0]  index;
  logic [tapehw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/tapehw_front.sv
// ----------------------------------------------------------------------------
// tapehw_front: item intake and classification
// Turns each input item into a bit pattern and count, keeps the checksum.
// ----------------------------------------------------------------------------
module tapehw_front (
  input  logic                    clk,
  input  logic                    rst_n,
  tapehw_in_if.sink               in_ch,
  input  tapehw_pkg::tapehw_qstat_t qstat_i,
  output logic                    push_o,
  output tapehw_pkg::tapehw_cmd_t cmd_o
);
  import tapehw_pkg::*;

  logic [VALUE_W-1:0] checksum_r;
  logic [VALUE_W-1:0] checksum_nxt;
  logic               accept;

  assign in_ch.ready = !qstat_i.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_o      = accept;

  always_comb begin
    checksum_nxt = checksum_r;
    cmd_o.bits   = '0;
    cmd_o.count  = '0;
    unique case (in_ch.action)
      ACT_SYNC: begin
        // ones in the top sync_count places, then the closing zero
        cmd_o.bits  = ~({PAT_W{1'b1}} >> in_ch.sync_count);
        cmd_o.count = COUNT_W'(in_ch.sync_count) + COUNT_W'(1);
      end
      ACT_WORD: begin
        cmd_o.bits   = {in_ch.value[7:0], in_ch.value[15:8], 16'h0};
        cmd_o.count  = COUNT_W'(16);
        checksum_nxt = checksum_r + in_ch.value;
      end
      ACT_CHECK: begin
        cmd_o.bits   = {checksum_r[7:0], checksum_r[15:8], 16'h0};
        cmd_o.count  = COUNT_W'(16);
        checksum_nxt = '0;
      end
      default: begin
        cmd_o.bits  = {in_ch.value[7:0], 24'h0};
        cmd_o.count = COUNT_W'(8);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checksum_r <= '0;
    end else if (accept) begin
      checksum_r <= checksum_nxt;
    end
  end

endmodule

FILE: hdl/tapehw_fifo.sv
// ----------------------------------------------------------------------------
// tapehw_fifo: command queue
// Short queue between intake and half-wave generation.
// ----------------------------------------------------------------------------
module tapehw_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_i,
  input  tapehw_pkg::tapehw_cmd_t   wr_data_i,
  input  logic                      pop_i,
  output tapehw_pkg::tapehw_cmd_t   rd_data_o,
  output tapehw_pkg::tapehw_qstat_t qstat_o
);
  import tapehw_pkg::*;

  tapehw_cmd_t        mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign qstat_o.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign qstat_o.empty = (count_r == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign rd_data_o     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (FIFO_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

FILE: hdl/tapehw_back.sv
// ----------------------------------------------------------------------------
// tapehw_back: half-wave generation
// Shifts out one command bit per half-wave with alternating polarity.
// ----------------------------------------------------------------------------
module tapehw_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tapehw_pkg::tapehw_cfg_t   cfg_i,
  input  tapehw_pkg::tapehw_qstat_t qstat_i,
  input  tapehw_pkg::tapehw_cmd_t   cmd_i,
  output logic                      pop_o,
  tapehw_out_if.source              out_ch
);
  import tapehw_pkg::*;

  logic                      busy_r;
  logic [PAT_W-1:0]          bits_r;
  logic [COUNT_W-1:0]        remain_r;
  logic                      neg_r;
  logic                      out_valid_r;
  logic signed [LEVEL_W-1:0] level_r;
  logic [LEN_W-1:0]          dur_r;
  logic                      last_r;
  logic                      advance;
  logic                      emit;
  logic                      final_wave;
  logic [LEVEL_W-1:0]        mag;

  assign advance    = !out_valid_r || out_ch.ready;
  assign emit       = busy_r && advance;
  assign final_wave = (remain_r == COUNT_W'(1));
  // load the next command as the current one sends its final half-wave
  assign pop_o      = !qstat_i.empty && (!busy_r || (emit && final_wave));
  assign mag        = {1'b0, cfg_i.amp};

  assign out_ch.valid    = out_valid_r;
  assign out_ch.level    = level_r;
  assign out_ch.duration = dur_r;
  assign out_ch.last     = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      remain_r    <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_r   <= 1'b1;
        bits_r   <= cmd_i.bits;
        remain_r <= cmd_i.count;
      end else if (emit) begin
        bits_r   <= bits_r << 1;
        remain_r <= remain_r - COUNT_W'(1);
        if (final_wave) begin
          busy_r <= 1'b0;
        end
      end
      if (advance) begin
        out_valid_r <= emit;
      end
      if (emit) begin
        neg_r   <= !neg_r;
        level_r <= neg_r ? LEVEL_W'(-mag) : mag;
        dur_r   <= bits_r[PAT_W-1] ? cfg_i.short_len : cfg_i.long_len;
        last_r  <= final_wave;
      end
    end
  end

endmodule

FILE: hdl/tape_halfwave_block_encoder.sv
// ----------------------------------------------------------------------------
// tape_halfwave_block_encoder: cassette half-wave bit encoder
// Turns sync runs, checksummed words, checksum words and bytes into a
// stream of half-waves of alternating polarity.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  - one transfer per item: action, value, sync_count.
//   out_ch - one transfer per half-wave: signed level, duration in samples,
//            and last, set on the final half-wave of each item.
//   cfg_ch - register writes (short length, long length, amplitude); always
//            ready; the user writes only while the encoder is idle, unchecked.
// Path: the first half-wave of an item passes the queue, the command shift
//   register and the output register before it is offered on out_ch.
// Throughput: one half-wave per cycle while out_ch.ready stays high; an item
//   has 16 half-waves for a word, 8 for a byte and sync_count + 1 for a sync
//   run, all from the single shift register of the back part. Back-to-back
//   items follow without a gap since the next command loads with the final
//   half-wave of the current one.
// Reset: polarity positive, checksum zero, registers 13 / 26 / 10000, queue
//   empty, no result pending.
// Stall: while out_ch.ready is low the output register holds its half-wave
//   and the back part waits; intake continues until the two-entry queue is
//   full, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module tape_halfwave_block_encoder (
  input  logic          clk,
  input  logic          rst_n,
  tapehw_in_if.sink     in_ch,
  tapehw_out_if.source  out_ch,
  tapehw_cfg_if.sink    cfg_ch
);
  import tapehw_pkg::*;

  tapehw_cfg_t   cfg_r;
  tapehw_qstat_t qstat;
  tapehw_cmd_t   push_cmd;
  tapehw_cmd_t   pop_cmd;
  logic          push;
  logic          pop;
  logic          cfg_write;

  // Register writes: always take them, ignore indexes beyond the list.
  assign cfg_ch.ready = 1'b1;
  assign cfg_write    = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_len <= SHORT_RESET;
      cfg_r.long_len  <= LONG_RESET;
      cfg_r.amp       <= AMP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_ch.index)
        REG_SHORT: cfg_r.short_len <= cfg_ch.data[LEN_W-1:0];
        REG_LONG:  cfg_r.long_len  <= cfg_ch.data[LEN_W-1:0];
        REG_AMP:   cfg_r.amp       <= cfg_ch.data[AMP_W-1:0];
        default:   ;
      endcase
    end
  end

  // Front: classify each item into a bit pattern, update the checksum.
  tapehw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .qstat_i (qstat),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // Queue: decouple intake from half-wave generation.
  tapehw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .wr_data_i (push_cmd),
    .pop_i     (pop),
    .rd_data_o (pop_cmd),
    .qstat_o   (qstat)
  );

  // Back: one half-wave per cycle into the output register unless stalled.
  tapehw_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_i   (cfg_r),
    .qstat_i (qstat),
    .cmd_i   (pop_cmd),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

  // Queue can never be both full and empty.
  a_qstat_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty at once");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result offered right after reset");

  // Amplitude write lands in the register.
  a_amp_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_write && cfg_ch.index == REG_AMP) |=> cfg_r.amp == $past(cfg_ch.data))
    else $error("amplitude write lost");

  // Never pop an empty queue.
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("command popped from empty queue");

endmodule

FILE: verif/tape_halfwave_block_encoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_halfwave_block_encoder_checker: half-wave predictor and scoreboard
// Watches the item, register and half-wave channels, works out the half-waves
// that every accepted item must produce and compares them in order with the
// half-waves that come out of the encoder.
// ----------------------------------------------------------------------------
module tape_halfwave_block_encoder_checker (
  input  logic  clk,
  input  logic  rst_n,
  tapehw_in_if  in_ch,
  tapehw_out_if out_ch,
  tapehw_cfg_if cfg_ch,
  output int    fail_count,
  output int    waves_pending
);
  import tapehw_pkg::*;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic [LEN_W-1:0]          duration;
    logic                      last;
  } half_wave_t;

  half_wave_t         wave_q[$];
  logic [LEN_W-1:0]   short_len;
  logic [LEN_W-1:0]   long_len;
  logic [AMP_W-1:0]   amp;
  logic               wave_negative;
  logic [VALUE_W-1:0] word_sum;

  task automatic queue_wave(input logic one_bit);
    half_wave_t         hw;
    logic [LEVEL_W-1:0] mag;
    mag         = LEVEL_W'(amp);
    hw.level    = wave_negative ? -mag : mag;
    hw.duration = one_bit ? short_len : long_len;
    hw.last     = 1'b0;
    wave_q.push_back(hw);
    wave_negative = ~wave_negative;
  endtask

  // MSB first
  task automatic queue_byte(input logic [7:0] bits8);
    for (int i = 7; i >= 0; i--) queue_wave(bits8[i]);
  endtask

  task automatic predict_item(input logic [ACTION_W-1:0] action,
                              input logic [VALUE_W-1:0] value,
                              input logic [SYNC_W-1:0] sync_count);
    half_wave_t tail;
    case (action)
      ACT_SYNC: begin
        for (int i = 0; i < sync_count; i++) queue_wave(1'b1);
        queue_wave(1'b0);
      end
      ACT_WORD: begin
        queue_byte(value[7:0]);
        queue_byte(value[15:8]);
        word_sum = word_sum + value;
      end
      ACT_CHECK: begin
        queue_byte(word_sum[7:0]);
        queue_byte(word_sum[15:8]);
        word_sum = '0;
      end
      default: begin
        queue_byte(value[7:0]);
      end
    endcase
    // flag the final half-wave of this item
    tail      = wave_q.pop_back();
    tail.last = 1'b1;
    wave_q.push_back(tail);
  endtask

  always @(posedge clk) begin
    half_wave_t want;
    if (!rst_n) begin
      short_len     = SHORT_RESET;
      long_len      = LONG_RESET;
      amp           = AMP_RESET;
      wave_negative = 1'b0;
      word_sum      = '0;
      fail_count    = 0;
      wave_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_SHORT: short_len = cfg_ch.data[LEN_W-1:0];
          REG_LONG:  long_len  = cfg_ch.data[LEN_W-1:0];
          REG_AMP:   amp       = cfg_ch.data[AMP_W-1:0];
          default:   ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (wave_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected half-wave: level %0d duration %0d last %0b",
                     $time, out_ch.level, out_ch.duration, out_ch.last);
          fail_count++;
        end else begin
          want = wave_q.pop_front();
          if (want.level !== out_ch.level || want.duration !== out_ch.duration ||
              want.last !== out_ch.last) begin
            if (fail_count < 10)
              $display({"%0t: half-wave mismatch: level %0d/%0d duration %0d/%0d",
                        " last %0b/%0b (exp/got)"},
                       $time, want.level, out_ch.level, want.duration, out_ch.duration,
                       want.last, out_ch.last);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_item(in_ch.action, in_ch.value, in_ch.sync_count);
    end
    waves_pending <= wave_q.size();
  end

endmodule

FILE: verif/tape_halfwave_block_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_halfwave_block_encoder_tb: testbench of the half-wave encoder
// Drives a directed set of sync runs, words, checksums and bytes under a few
// register settings, then random tape records and noise items under random
// settings, with random gaps on both channels. The checker predicts every
// half-wave; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tape_halfwave_block_encoder_tb;
  import tapehw_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int PHASE_ITEMS   = 76;
  localparam int RANDOM_PHASES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;

  // index outside the register map; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   waves_pending;

  // both sides run without gaps while this is set
  bit no_idle       = 1'b0;
  // ask the receiver for one long hold-off
  bit long_hold_req = 1'b0;

  tapehw_in_if  in_ch();
  tapehw_out_if out_ch();
  tapehw_cfg_if cfg_ch();

  tape_halfwave_block_encoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tape_halfwave_block_encoder_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .waves_pending (waves_pending)
  );

  always #(CLK_HALF) clk = ~clk;

  // Offer one item after a random gap and hold it until the transfer.
  // valid stays high afterwards so back-to-back items need no extra edge.
  task automatic send_item(input logic [ACTION_W-1:0] action,
                           input logic [VALUE_W-1:0] value,
                           input logic [SYNC_W-1:0] sync_count);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= action;
    in_ch.value      <= value;
    in_ch.sync_count <= sync_count;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait until every predicted half-wave has come out and let the
  // pipeline go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (waves_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Write all registers while idle. Length writes carry random upper bits,
  // which the encoder must drop.
  task automatic load_regs(input logic [LEN_W-1:0] short_len,
                           input logic [LEN_W-1:0] long_len,
                           input logic [AMP_W-1:0] amp);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_SPARE, junk);
    write_reg(REG_SHORT, {junk[CFG_DATA_W-1:LEN_W], short_len});
    write_reg(REG_LONG, {~junk[CFG_DATA_W-1:LEN_W], long_len});
    write_reg(REG_AMP, amp);
    cfg_ch.valid <= 1'b0;
  endtask

  // Length setting: favor the extremes of the legal range.
  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 4))
      0:       return LEN_W'(1);
      1:       return '1;
      default: return LEN_W'($urandom_range(1, 255));
    endcase
  endfunction

  // Any action code, drawn uniformly.
  function automatic logic [ACTION_W-1:0] any_action();
    return ACTION_W'($urandom_range(0, 3));
  endfunction

  // Receiver: random ready gaps per half-wave, plus one long hold-off on
  // request so the queue fills and the encoder stalls its input.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (long_hold_req) begin
        gap           = HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Sender and register writes.
  initial begin
    logic [AMP_W-1:0] amp;
    int               n;
    bit               paused;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_SYNC;
    in_ch.value      <= '0;
    in_ch.sync_count <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_SHORT;
    cfg_ch.data      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: shortest and longest sync runs (value must be ignored),
    // words at the extremes, a checksum that wrapped, a checksum of zero,
    // and bytes whose upper half must be ignored.
    send_item(ACT_SYNC, 16'hFFFF, 5'd0);
    send_item(ACT_SYNC, 16'h0000, 5'd31);
    send_item(ACT_WORD, 16'h0000, 5'd31);
    send_item(ACT_WORD, 16'hFFFF, 5'd0);
    send_item(ACT_WORD, 16'h8001, 5'd17);
    send_item(ACT_CHECK, 16'hFFFF, 5'd31);
    send_item(ACT_CHECK, 16'h0000, 5'd0);
    send_item(ACT_BYTE, 16'hFF00, 5'd31);
    send_item(ACT_BYTE, 16'h00FF, 5'd0);
    send_item(ACT_WORD, 16'h0002, 5'd10);
    send_item(ACT_BYTE, 16'h5AA5, 5'd21);
    send_item(ACT_CHECK, 16'h1234, 5'd5);
    settle();

    // Extreme lengths and full amplitude.
    load_regs(LEN_W'(1), '1, '1);
    send_item(ACT_WORD, 16'hA55A, 5'd0);
    send_item(ACT_SYNC, 16'h0F0F, 5'd3);
    send_item(ACT_CHECK, 16'h0000, 5'd0);
    send_item(ACT_BYTE, 16'h3C96, 5'd0);
    settle();

    // Swapped extremes and zero amplitude: level is 0 on both polarities.
    load_regs('1, LEN_W'(1), '0);
    send_item(ACT_SYNC, 16'h0000, 5'd2);
    send_item(ACT_WORD, 16'h1234, 5'd0);
    send_item(ACT_BYTE, 16'hC30F, 5'd0);
    settle();

    // Zero lengths pass straight through as zero durations.
    load_regs('0, '0, AMP_W'(1));
    send_item(ACT_WORD, 16'hF00F, 5'd0);
    send_item(ACT_SYNC, 16'h0000, 5'd1);
    settle();

    // Random part: mostly tape records (leader, checksummed words, checksum)
    // with random content, the rest single items of any kind.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       amp = '0;
        1:       amp = '1;
        default: amp = AMP_W'($urandom);
      endcase
      load_regs(pick_len(), pick_len(), amp);
      no_idle = (ph == 1);
      if (ph == 2) long_hold_req = 1'b1;
      n      = 0;
      paused = 1'b0;
      while (n < PHASE_ITEMS) begin
        // once, stop offering until the encoder has caught up
        if (ph == 3 && !paused && n >= PHASE_ITEMS / 2) begin
          settle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 3) == 0) begin
          send_item(any_action(), VALUE_W'($urandom), SYNC_W'($urandom));
          n++;
        end else begin
          send_item(ACT_SYNC, VALUE_W'($urandom), SYNC_W'($urandom_range(4, 31)));
          n++;
          repeat ($urandom_range(1, 6)) begin
            send_item(ACT_WORD, VALUE_W'($urandom), SYNC_W'($urandom));
            n++;
          end
          send_item(ACT_CHECK, VALUE_W'($urandom), SYNC_W'($urandom));
          n++;
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("tape_halfwave_block_encoder test passed");
    end else begin
      $display("tape_halfwave_block_encoder test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("tape_halfwave_block_encoder test failed");
    $finish;
  end

endmodule
